// ===== sv/mswu_pkg.sv =====
// Package: shared types, codes and constants of the modem session wakeup unit.
package mswu_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_ESC   = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic {
    KIND_TX   = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  // Session outcomes
  typedef enum logic [2:0] {
    OC_LINE    = 3'd0,
    OC_EMSI    = 3'd1,
    OC_ESCAPE  = 3'd2,
    OC_NOANS   = 3'd3,
    OC_CARRIER = 3'd4
  } outcome_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROUND_TICKS   = 2'd0,
    REG_SESSION_TICKS = 2'd1,
    REG_EMSI_ENABLED  = 2'd2,
    REG_STOP_CHAR     = 2'd3
  } reg_e;

  // Characters
  localparam logic [7:0] CH_XON   = 8'd17;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_STAR  = 8'd42;

  localparam logic [1:0]  XON_ROUNDS = 2'd2;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  // Register reset values
  localparam logic [15:0] RST_ROUND_TICKS   = 16'd100;
  localparam logic [15:0] RST_SESSION_TICKS = 16'd3000;
  localparam logic        RST_EMSI_ENABLED  = 1'b1;
  localparam logic [7:0]  RST_STOP_CHAR     = 8'd19;

  // Output queue depth (at least two)
  localparam int unsigned OQ_DEPTH = 4;

  typedef struct packed {
    logic [15:0] round_ticks;
    logic [15:0] session_ticks;
    logic        emsi_enabled;
    logic [7:0]  stop_char;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic [15:0] session_count;
    logic [15:0] round_count;
    logic [1:0]  xon_left;
    logic        send_space_next;
    logic        got_char;
    logic        in_line;
    logic        line_done;
    logic        escape_pending;
  } state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx_byte;
    outcome_e   outcome;
    logic       last;
  } res_t;

  // Results of one item, handed to the output queue
  typedef struct packed {
    logic [1:0]     n;
    res_t [1:0]     r;
  } push_t;

endpackage

// ===== sv/mswu_regs.sv =====
// APB configuration registers of the wakeup unit.
module mswu_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mswu_pkg::cfg_t    cfg_o
);
  import mswu_pkg::*;

  cfg_t  cfg_q;
  logic  wr_en;
  reg_e  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_e'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.round_ticks   <= RST_ROUND_TICKS;
      cfg_q.session_ticks <= RST_SESSION_TICKS;
      cfg_q.emsi_enabled  <= RST_EMSI_ENABLED;
      cfg_q.stop_char     <= RST_STOP_CHAR;
    end else if (wr_en) begin
      case (idx)
        REG_ROUND_TICKS:   cfg_q.round_ticks   <= pwdata[15:0];
        REG_SESSION_TICKS: cfg_q.session_ticks <= pwdata[15:0];
        REG_EMSI_ENABLED:  cfg_q.emsi_enabled  <= pwdata[0];
        REG_STOP_CHAR:     cfg_q.stop_char     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ROUND_TICKS:   prdata = {16'd0, cfg_q.round_ticks};
      REG_SESSION_TICKS: prdata = {16'd0, cfg_q.session_ticks};
      REG_EMSI_ENABLED:  prdata = {31'd0, cfg_q.emsi_enabled};
      REG_STOP_CHAR:     prdata = {24'd0, cfg_q.stop_char};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/mswu_engine.sv =====
// Input register, session state and the per-item step logic.
module mswu_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mswu_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_op_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_carrier_i,
  input  logic              room_i,
  output mswu_pkg::push_t   push_o
);
  import mswu_pkg::*;

  logic       in_vld_q;
  op_e        in_op_q;
  logic [7:0] in_byte_q;
  logic       in_car_q;
  logic       fire;

  state_t     st_q, st_d;
  res_t [1:0] res;
  logic [1:0] n;
  logic       do_rs;
  logic       fin;
  outcome_e   oc;

  // step fires once the queue can take two results
  assign fire       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_op_q   <= op_e'(in_op_i);
      in_byte_q <= in_byte_i;
      in_car_q  <= in_carrier_i;
    end
  end

  // next state and results of the registered item
  always_comb begin
    st_d  = st_q;
    res   = '0;
    n     = 2'd0;
    do_rs = 1'b0;
    fin   = 1'b0;
    oc    = OC_LINE;

    case (in_op_q)
      OP_START: begin
        st_d.active          = 1'b1;
        st_d.session_count   = 16'd0;
        st_d.xon_left        = XON_ROUNDS;
        st_d.send_space_next = 1'b0;
        st_d.got_char        = 1'b0;
        st_d.in_line         = 1'b0;
        st_d.line_done       = 1'b0;
        st_d.escape_pending  = 1'b0;
        do_rs                = 1'b1;
      end
      OP_TICK: begin
        if (st_q.active) begin
          if (st_q.session_count != CNT_MAX) begin
            st_d.session_count = st_q.session_count + 16'd1;
          end
          if (st_q.round_count != CNT_MAX) begin
            st_d.round_count = st_q.round_count + 16'd1;
          end
          if (st_q.line_done) begin
            fin = 1'b1;
            oc  = OC_LINE;
          end else if (st_d.round_count >= cfg_i.round_ticks) begin
            if (st_q.escape_pending) begin
              fin = 1'b1;
              oc  = OC_ESCAPE;
            end else begin
              do_rs = 1'b1;
            end
          end
        end
      end
      OP_BYTE: begin
        if (st_q.active) begin
          if (!st_q.in_line && cfg_i.emsi_enabled && in_byte_q == CH_STAR) begin
            fin = 1'b1;
            oc  = OC_EMSI;
          end else if (in_byte_q == CH_CR && st_q.got_char) begin
            // end of reply line: halt remote output once
            if (st_q.in_line && !st_q.line_done) begin
              res[0].kind    = KIND_TX;
              res[0].tx_byte = cfg_i.stop_char;
              n              = 2'd1;
            end
            st_d.in_line   = 1'b0;
            st_d.line_done = 1'b1;
          end else if (in_byte_q >= CH_SPACE) begin
            // leading spaces do not open a line
            if (st_q.in_line || in_byte_q != CH_SPACE) begin
              st_d.in_line = 1'b1;
            end
            if (!st_q.got_char) begin
              st_d.got_char    = 1'b1;
              st_d.round_count = 16'd0;
            end
          end
        end
      end
      OP_ESC: begin
        if (st_q.active) begin
          st_d.escape_pending = 1'b1;
        end
      end
      default: ;
    endcase

    // round start: give up, or send the wakeup bytes
    if (do_rs) begin
      if (st_d.session_count >= cfg_i.session_ticks || !in_car_q) begin
        fin = 1'b1;
        oc  = in_car_q ? OC_NOANS : OC_CARRIER;
      end else begin
        if (st_d.xon_left != 2'd0) begin
          st_d.xon_left     = st_d.xon_left - 2'd1;
          res[n[0]].kind    = KIND_TX;
          res[n[0]].tx_byte = CH_XON;
          n                 = n + 2'd1;
        end
        res[n[0]].kind       = KIND_TX;
        res[n[0]].tx_byte    = st_d.send_space_next ? CH_SPACE : CH_CR;
        n                    = n + 2'd1;
        st_d.send_space_next = !st_d.send_space_next;
        st_d.round_count     = 16'd0;
      end
    end

    if (fin) begin
      res[n[0]].kind    = KIND_DONE;
      res[n[0]].tx_byte = 8'd0;
      res[n[0]].outcome = oc;
      n                 = n + 2'd1;
      st_d.active       = 1'b0;
    end

    // mark the final result of the item
    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  // session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  assign push_o.n = fire ? n : 2'd0;
  assign push_o.r = res;

endmodule

// ===== sv/mswu_outq.sv =====
// Output queue: takes up to two results per cycle, releases one per transaction.
module mswu_outq #(
  parameter int unsigned Depth = mswu_pkg::OQ_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mswu_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mswu_pkg::res_t    out_o
);
  import mswu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntRoom = CntW'(Depth - 2);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q, wr_nx, wr_nx2, rd_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign wr_nx       = ptr_inc(wr_q);
  assign wr_nx2      = ptr_inc(wr_nx);
  assign rd_nx       = ptr_inc(rd_q);
  assign cnt_d       = cnt_q + CntW'(push_i.n) - CntW'(pop);
  assign room_o      = cnt_q <= CntRoom;
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) begin
        rd_q <= rd_nx;
      end
      if (push_i.n == 2'd1) begin
        wr_q <= wr_nx;
      end else if (push_i.n == 2'd2) begin
        wr_q <= wr_nx2;
      end
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r[0];
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.r[1];
    end
  end

endmodule

// ===== sv/modem_session_wakeup_unit.sv =====
// Top level of the modem session wakeup unit.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser operation, tdata rx_byte, carrier
//  m_axis    out  tvalid/tready             tuser kind, tdata tx_byte, outcome, tlast
//  apb       in   psel/penable, pready=1    four registers at 0x0, 0x4, 0x8, 0xC
//
// An item is held in the input register and stepped there once the queue has room; its
// results (zero to two) are then registered into the output queue and leave it in order.
// One item is taken per cycle while the queue has two free entries; the output side,
// one result per transaction, sets the sustained rate when items yield two results.
// Reset clears the session state and the queue at once; no clearing pass.
// A stalled output fills the queue and then holds s_axis_tready low.
module modem_session_wakeup_unit #(
  parameter int unsigned OutDepth = mswu_pkg::OQ_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] carrier, [15:9] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [10:8] outcome, [15:11] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mswu_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;
  res_t  head;

  // configuration registers
  mswu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // session step
  mswu_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_byte_i    (s_axis_tdata[7:0]),
    .in_carrier_i (s_axis_tdata[8]),
    .room_i       (room),
    .push_o       (push)
  );

  // result queue
  mswu_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (head)
  );

  assign m_axis_tdata = {5'd0, head.outcome, head.tx_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== sv/mswu_checker.sv =====
// Port-level checker of the wakeup unit and its bind.
module mswu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // input only backs up behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // a session end is always the final result of its item
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("session end not marked last");

  // unused field of each result kind reads zero
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[7:0] == 8'd0)
                                    : (m_axis_tdata[10:8] == 3'd0)))
    else $error("unused result field not zero");

endmodule

bind modem_session_wakeup_unit mswu_checker u_mswu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
